[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the duty mixer checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is asserted.
`define MWDM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("mixer assertion failed");

// Assertion that is also checked across the reset edge.
`define MWDM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("mixer reset assertion failed");

`endif

[design/mwdm_pkg.sv]
// ---------------------------------------------------------------------------
// mwdm_pkg
// Types, codes and helper functions shared by the duty mixer modules.
// ---------------------------------------------------------------------------
package mwdm_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned DUTY_W    = 10;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned AXIS_W    = 20;
    localparam int unsigned WIDE_W    = 42;
    localparam int unsigned IN_DATA_W = 24;
    localparam int unsigned OUT_DATA_W = 80;

    localparam logic [BYTE_W-1:0] CENTER_BYTE  = 8'd128;
    localparam logic [TICK_W-1:0] TICK_MAX     = 16'hFFFF;
    localparam logic [CFG_W-1:0]  TIMEOUT_RST  = 16'd10;
    localparam logic [CFG_W-1:0]  GAIN_RST     = 16'd58982;

    // Item kinds carried on the input tuser.
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_FAILSAFE_TIMEOUT = 1'b0;
    localparam logic CFG_OMEGA_GAIN       = 1'b1;

    typedef struct packed {
        logic              fired;
        logic [BYTE_W-1:0] rot;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] x;
    } t_mix_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Joystick byte to axis value in units of 1/256: 999*256 - 1998*b.
    function automatic logic signed [AXIS_W-1:0] axis_value(input logic [BYTE_W-1:0] b);
        logic signed [31:0] v;
        v = 32'sd255744 - 32'sd1998 * $signed({24'd0, b});
        return v[AXIS_W-1:0];
    endfunction

endpackage

[design/mwdm_queue.sv]
// ---------------------------------------------------------------------------
// mwdm_queue
// Two-entry queue that decouples the front classifier from the mixer.
// ---------------------------------------------------------------------------
module mwdm_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  mwdm_pkg::t_mix_item   i_item,
    input  logic                  i_pop,
    output mwdm_pkg::t_mix_item   o_item,
    output mwdm_pkg::t_queue_status o_status
);
    import mwdm_pkg::*;

    t_mix_item  r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_mem[r_wr_ptr] <= i_item;
                r_wr_ptr        <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/mwdm_front.sv]
// ---------------------------------------------------------------------------
// mwdm_front
// Accepts ticks and packets, tracks silence and applies the failsafe.
// ---------------------------------------------------------------------------
module mwdm_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_func,
    input  logic [mwdm_pkg::BYTE_W-1:0] i_x,
    input  logic [mwdm_pkg::BYTE_W-1:0] i_y,
    input  logic [mwdm_pkg::BYTE_W-1:0] i_rot,
    input  logic [mwdm_pkg::CFG_W-1:0] i_timeout,
    input  logic                       i_queue_full,
    output logic                       o_ready,
    output logic                       o_push,
    output mwdm_pkg::t_mix_item        o_item
);
    import mwdm_pkg::*;

    logic [BYTE_W-1:0] r_held_x, r_held_y, r_held_rot;
    logic [TICK_W-1:0] r_silence;

    logic [BYTE_W-1:0] n_held_x, n_held_y, n_held_rot;
    logic [TICK_W-1:0] n_silence;
    logic              fire;

    assign o_ready = !i_queue_full;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        if (i_func == FUNC_PACKET) begin
            n_held_x   = i_x;
            n_held_y   = i_y;
            n_held_rot = i_rot;
            n_silence  = '0;
        end else begin
            n_held_x   = r_held_x;
            n_held_y   = r_held_y;
            n_held_rot = r_held_rot;
            n_silence  = (r_silence == TICK_MAX) ? r_silence : r_silence + 16'd1;
        end
        fire = (n_silence > i_timeout);
        if (fire) begin
            n_held_x   = CENTER_BYTE;
            n_held_y   = CENTER_BYTE;
            n_held_rot = CENTER_BYTE;
        end
        o_item.fired = fire;
        o_item.x     = n_held_x;
        o_item.y     = n_held_y;
        o_item.rot   = n_held_rot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_x   <= CENTER_BYTE;
            r_held_y   <= CENTER_BYTE;
            r_held_rot <= CENTER_BYTE;
            r_silence  <= '0;
        end else if (o_push) begin
            r_held_x   <= n_held_x;
            r_held_y   <= n_held_y;
            r_held_rot <= n_held_rot;
            r_silence  <= n_silence;
        end
    end

endmodule

[design/mwdm_back.sv]
// ---------------------------------------------------------------------------
// mwdm_back
// Maps held bytes to axis values, mixes four wheel speeds and splits them
// into forward and reverse compare values in an output register.
// ---------------------------------------------------------------------------
module mwdm_back #(
    parameter int unsigned DUTY_LIMIT = 999
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_queue_empty,
    input  mwdm_pkg::t_mix_item           i_item,
    input  logic [mwdm_pkg::CFG_W-1:0]    i_gain,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mwdm_pkg::OUT_DATA_W-1:0] o_data,
    output logic                          o_fired
);
    import mwdm_pkg::*;

    localparam logic signed [WIDE_W-1:0] LIM = $signed(WIDE_W'(DUTY_LIMIT) << 24);

    typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_MIX} t_state;

    t_state                    r_state;
    logic signed [AXIS_W-1:0]  r_vx, r_vy, r_om;
    logic                      r_fired;
    logic signed [WIDE_W-1:0]  r_a, r_b, r_rot;
    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic                      r_out_fired;

    logic signed [AXIS_W:0]    sum_neg, sum_dif;
    logic signed [36:0]        prod;
    logic                      out_free;

    // Returns {rev, fwd} for one clamped speed in units of 2^-24.
    function automatic logic [2*DUTY_W-1:0] split(input logic signed [WIDE_W-1:0] w);
        logic signed [WIDE_W-1:0] c;
        logic [WIDE_W-1:0]        m;
        logic [2*DUTY_W-1:0]      r;
        c = w;
        if (w > LIM) c = LIM;
        else if (w < -LIM) c = -LIM;
        r = '0;
        m = '0;
        if (c > 0) begin
            r[DUTY_W-1:0] = c[33:24];
        end else if (c < 0) begin
            m = WIDE_W'(-c);
            r[2*DUTY_W-1:DUTY_W] = m[33:24];
        end
        return r;
    endfunction

    assign o_pop    = (r_state == ST_IDLE) && !i_queue_empty;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out_data;
    assign o_fired  = r_out_fired;

    assign sum_neg = -($signed({r_vx[AXIS_W-1], r_vx}) + $signed({r_vy[AXIS_W-1], r_vy}));
    assign sum_dif = $signed({r_vy[AXIS_W-1], r_vy}) - $signed({r_vx[AXIS_W-1], r_vx});
    assign prod    = $signed({1'b0, i_gain}) * r_om;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == ST_MIX) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_vx    <= axis_value(i_item.x);
                        r_vy    <= axis_value(i_item.y);
                        r_om    <= axis_value(i_item.rot);
                        r_fired <= i_item.fired;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_a     <= WIDE_W'(sum_neg) <<< 16;
                    r_b     <= WIDE_W'(sum_dif) <<< 16;
                    r_rot   <= WIDE_W'(prod);
                    r_state <= ST_MIX;
                end
                ST_MIX: begin
                    // Hold here until the previous result has been taken.
                    if (out_free) begin
                        r_out_data  <= {split(r_a - r_rot), split(r_b + r_rot),
                                        split(r_b - r_rot), split(r_a + r_rot)};
                        r_out_fired <= r_fired;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

[design/mecanum_wheel_duty_mixer_unit.sv]
// ---------------------------------------------------------------------------
// mecanum_wheel_duty_mixer_unit
// Joystick failsafe and mecanum mixer producing four wheel compare pairs.
// ---------------------------------------------------------------------------
// Flow: a taken word is queued, then passes the map, multiply and mix steps
// of the mixer into the output register; the mixer takes no new word until the
// last has left the mix step; the front keeps accepting into a two-word queue.
// Reset: synchronous active-low; held bytes return to 128, silence to zero,
// registers to their defaults, and queue and output are emptied.
module mecanum_wheel_duty_mixer_unit #(
    parameter int unsigned DUTY_LIMIT = 999
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // x_byte [7:0], y_byte [15:8], rot_byte [23:16]
    input  logic [mwdm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // func [0]
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // wheel1_fwd, wheel1_rev, wheel2_fwd, wheel2_rev, wheel3_fwd, wheel3_rev,
    // wheel4_fwd, wheel4_rev: ten bits each from bit 0 up
    output logic [mwdm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // failsafe_active [0]
    output logic        m_axis_tuser,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [mwdm_pkg::CFG_W-1:0] i_cfg_wdata
);
    import mwdm_pkg::*;

    logic [CFG_W-1:0] r_failsafe_timeout;
    logic [CFG_W-1:0] r_omega_gain;

    logic          push, pop;
    t_mix_item     front_item, head_item;
    t_queue_status q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_failsafe_timeout <= TIMEOUT_RST;
            r_omega_gain       <= GAIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FAILSAFE_TIMEOUT: r_failsafe_timeout <= i_cfg_wdata;
                CFG_OMEGA_GAIN:       r_omega_gain       <= i_cfg_wdata;
                default:              r_omega_gain       <= r_omega_gain;
            endcase
        end
    end

    mwdm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .i_func       (s_axis_tuser),
        .i_x          (s_axis_tdata[7:0]),
        .i_y          (s_axis_tdata[15:8]),
        .i_rot        (s_axis_tdata[23:16]),
        .i_timeout    (r_failsafe_timeout),
        .i_queue_full (q_status.full),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_item       (front_item)
    );

    mwdm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    mwdm_back #(
        .DUTY_LIMIT (DUTY_LIMIT)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (q_status.empty),
        .i_item        (head_item),
        .i_gain        (r_omega_gain),
        .o_pop         (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_fired       (m_axis_tuser)
    );

endmodule

[design/mwdm_checker.sv]
// ---------------------------------------------------------------------------
// mwdm_checker
// Port-level checks of the duty mixer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mwdm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [79:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic        no_both;
    logic        stalled;
    logic [80:0] out_word;

    // A wheel never drives forward and reverse at the same time.
    assign no_both = !((m_axis_tdata[9:0] != 10'd0) && (m_axis_tdata[19:10] != 10'd0)) &&
                     !((m_axis_tdata[29:20] != 10'd0) && (m_axis_tdata[39:30] != 10'd0)) &&
                     !((m_axis_tdata[49:40] != 10'd0) && (m_axis_tdata[59:50] != 10'd0)) &&
                     !((m_axis_tdata[69:60] != 10'd0) && (m_axis_tdata[79:70] != 10'd0));

    assign stalled  = m_axis_tvalid && !m_axis_tready;
    assign out_word = {m_axis_tuser, m_axis_tdata};

    `MWDM_ASSERT_ALWAYS(a_idle_after_reset, i_clk, !i_rst_n |=> !m_axis_tvalid)
    `MWDM_ASSERT(a_hold_stalled, i_clk, i_rst_n, stalled |=> m_axis_tvalid && $stable(out_word))
    `MWDM_ASSERT(a_one_direction, i_clk, i_rst_n, m_axis_tvalid |-> no_both)
    `MWDM_ASSERT(a_failsafe_stops, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 80'd0)

endmodule

bind mecanum_wheel_duty_mixer_unit mwdm_checker u_mwdm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
